// ===== hdl/dq_pkg.sv =====
// Shared constants, codes and the result type of the double-ended queue.
`default_nettype none

package dq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [VALUE_W-1:0] data;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/dq_ram.sv =====
// Entry store: one write port and one read port with registered read data.
`default_nettype none

module dq_ram #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
    parameter int AW         = $clog2(DEPTH)
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [DATA_WIDTH-1:0] wdata,
    input  wire logic                  re,
    input  wire logic [AW-1:0]         raddr,
    output logic      [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dq_ctrl.sv =====
// Sequencer that runs each request against the entry store and holds the result.
`default_nettype none

module dq_ctrl #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
    parameter int AW         = $clog2(DEPTH),
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [dq_pkg::OP_W-1:0]     in_op,
    input  wire logic [dq_pkg::VALUE_W-1:0]  in_value,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output dq_pkg::result_t                  out_result,
    output logic                             ram_we,
    output logic      [AW-1:0]               ram_waddr,
    output logic      [DATA_WIDTH-1:0]       ram_wdata,
    output logic                             ram_re,
    output logic      [AW-1:0]               ram_raddr,
    input  wire logic [DATA_WIDTH-1:0]       ram_rdata
);

    localparam int SW = CW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_DEL_FRONT,
        S_DEL_BACK,
        S_SCAN,
        S_SHIFT
    } state_t;

    state_t                    state_reg, state_next;
    logic [AW-1:0]             head_reg, head_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             idx_reg, idx_next;
    logic [dq_pkg::OP_W-1:0]   op_reg, op_next;
    logic [DATA_WIDTH-1:0]     word_reg, word_next;
    logic                      out_valid_reg, out_valid_next;
    dq_pkg::result_t           result_reg, result_next;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic                      match;
    logic [AW-1:0]             head_inc;
    logic [AW-1:0]             head_dec;
    logic [CW-1:0]             count_dec;
    logic [CW-1:0]             idx_p1;
    logic [CW-1:0]             idx_p2;
    logic                      more_after;
    logic [DATA_WIDTH+31:0]    value_ext;
    logic [DATA_WIDTH-1:0]     word_in;

    // Ring position of the element k places behind the front.
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(k);
        if (s >= SW'(DEPTH))
        begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [dq_pkg::COUNT_W-1:0] to_count(input logic [CW-1:0] c);
        logic [CW+dq_pkg::COUNT_W-1:0] e;
        e = {{dq_pkg::COUNT_W{1'b0}}, c};
        return e[dq_pkg::COUNT_W-1:0];
    endfunction

    function automatic logic [dq_pkg::VALUE_W-1:0] to_value(input logic [DATA_WIDTH-1:0] d);
        logic [DATA_WIDTH+dq_pkg::VALUE_W-1:0] e;
        e = {{dq_pkg::VALUE_W{1'b0}}, d};
        return e[dq_pkg::VALUE_W-1:0];
    endfunction

    function automatic dq_pkg::result_t make_result(input logic [DATA_WIDTH-1:0] d,
                                                    input dq_pkg::status_t st,
                                                    input logic [CW-1:0] c);
        dq_pkg::result_t r;
        r.data   = to_value(d);
        r.status = st;
        r.count  = to_count(c);
        return r;
    endfunction

    assign in_ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    // Only the low DATA_WIDTH bits of the word are stored; wider entries see zeros above.
    assign value_ext = {{DATA_WIDTH{1'b0}}, in_value};
    assign word_in   = value_ext[DATA_WIDTH-1:0];

    assign full       = (count_reg == CW'(DEPTH));
    assign empty      = (count_reg == '0);
    assign match      = (ram_rdata == word_reg);
    assign head_inc   = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec   = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign count_dec  = count_reg - 1'b1;
    assign idx_p1     = idx_reg + 1'b1;
    assign idx_p2     = idx_reg + 2'd2;
    assign more_after = (SW'(idx_reg) + SW'(2)) < SW'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        op_next        = op_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg && !out_ready;
        result_next    = result_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = word_reg;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = in_op;
                    word_next = word_in;
                    unique case (in_op) inside
                        dq_pkg::OP_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                result_next = make_result('0, dq_pkg::STATUS_FULL, count_reg);
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = slot(head_reg, count_reg);
                                ram_wdata   = word_in;
                                count_next  = count_reg + 1'b1;
                                result_next = make_result('0, dq_pkg::STATUS_OK, count_next);
                            end
                        end
                        dq_pkg::OP_PUSH_FRONT:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                result_next = make_result('0, dq_pkg::STATUS_FULL, count_reg);
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = head_dec;
                                ram_wdata   = word_in;
                                head_next   = head_dec;
                                count_next  = count_reg + 1'b1;
                                result_next = make_result('0, dq_pkg::STATUS_OK, count_next);
                            end
                        end
                        dq_pkg::OP_POP_BACK, dq_pkg::OP_POP_FRONT, dq_pkg::OP_DELETE:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                result_next = make_result('0, dq_pkg::STATUS_EMPTY, count_reg);
                            end
                            else
                            begin
                                ram_re = 1'b1;
                                if (in_op == dq_pkg::OP_POP_BACK)
                                begin
                                    ram_raddr  = slot(head_reg, count_dec);
                                    state_next = S_POP;
                                end
                                else if (in_op == dq_pkg::OP_POP_FRONT)
                                begin
                                    ram_raddr  = head_reg;
                                    state_next = S_POP;
                                end
                                else
                                begin
                                    ram_raddr  = head_reg;
                                    state_next = S_DEL_FRONT;
                                end
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            result_next = make_result('0, dq_pkg::STATUS_OK, count_reg);
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (op_reg == dq_pkg::OP_POP_FRONT)
                begin
                    head_next = head_inc;
                end
                count_next     = count_dec;
                out_valid_next = 1'b1;
                result_next    = make_result(ram_rdata, dq_pkg::STATUS_OK, count_dec);
                state_next     = S_IDLE;
            end
            S_DEL_FRONT:
            begin
                if (match)
                begin
                    head_next      = head_inc;
                    count_next     = count_dec;
                    out_valid_next = 1'b1;
                    result_next    = make_result('0, dq_pkg::STATUS_OK, count_dec);
                    state_next     = S_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot(head_reg, count_dec);
                    state_next = S_DEL_BACK;
                end
            end
            S_DEL_BACK:
            begin
                if (match)
                begin
                    count_next     = count_dec;
                    out_valid_next = 1'b1;
                    result_next    = make_result('0, dq_pkg::STATUS_OK, count_dec);
                    state_next     = S_IDLE;
                end
                else if (count_reg <= CW'(2))
                begin
                    out_valid_next = 1'b1;
                    result_next = make_result('0, dq_pkg::STATUS_NOT_FOUND, count_reg);
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next   = CW'(1);
                    ram_re     = 1'b1;
                    ram_raddr  = slot(head_reg, CW'(1));
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Read data is the entry at idx. On a match or if more remain, the next entry is read.
                if (match)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot(head_reg, idx_p1);
                    state_next = S_SHIFT;
                end
                else if (more_after)
                begin
                    idx_next   = idx_p1;
                    ram_re     = 1'b1;
                    ram_raddr  = slot(head_reg, idx_p1);
                end
                else
                begin
                    out_valid_next = 1'b1;
                    result_next = make_result('0, dq_pkg::STATUS_NOT_FOUND, count_reg);
                    state_next  = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                // Read data is the entry at idx+1; it moves down one place while the next, if any, is read.
                ram_we    = 1'b1;
                ram_waddr = slot(head_reg, idx_reg);
                ram_wdata = ram_rdata;
                if (more_after)
                begin
                    idx_next  = idx_p1;
                    ram_re    = 1'b1;
                    ram_raddr = slot(head_reg, idx_p2);
                end
                else
                begin
                    count_next     = count_dec;
                    out_valid_next = 1'b1;
                    result_next    = make_result('0, dq_pkg::STATUS_OK, count_dec);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        word_reg   <= word_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

// ===== hdl/double_ended_queue.sv =====
// Top level of the double-ended queue: stream ports, sequencer and entry store.
//
// A bounded double-ended queue of DEPTH words kept as a ring in one synchronous
// memory. Each input transaction carries a request in s_axis_tuser and a word in
// s_axis_tdata; each request gives exactly one output transaction with the popped
// word, a status and the entry count. One request is worked at a time, and a new
// one is taken once the previous result has been taken. Push at either end, and any
// request on an empty queue, sets its result as it is accepted; pop at either end
// first reads the entry from memory. Delete by value reads the front entry, then the
// back entry, then scans the middle and closes the gap one entry per cycle through the
// single memory read port. The result then waits in an output register, and the next
// request is accepted in the cycle after it is taken.
// The memory is not cleared after reset; only held entries are ever read.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,   // [31:0] data_out, [36:32] count, [39:37] zero
    output logic      [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    dq_pkg::result_t       result;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    dq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (s_axis_tuser),
        .in_value   (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    dq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_ram (
        .clk        (clk),
        .we         (ram_we),
        .waddr      (ram_waddr),
        .wdata      (ram_wdata),
        .re         (ram_re),
        .raddr      (ram_raddr),
        .rdata      (ram_rdata)
    );

    assign m_axis_tdata = {3'b000, result.count, result.data};
    assign m_axis_tuser = result.status;

endmodule

`default_nettype wire
